// ----- rtl/core/lprs_pkg.sv -----
// ----------------------------------------------------------------------------
// lprs_pkg
// Shared types and constants for the LED panel row scan sequencer: item
// opcodes, result kinds, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lprs_pkg;

   typedef enum logic [1:0] {
      OP_WRITE    = 2'd0,
      OP_TICK     = 2'd1,
      OP_SCAN_ON  = 2'd2,
      OP_SCAN_OFF = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACK  = 2'd0,
      KIND_PIN  = 2'd1,
      KIND_DATA = 2'd2
   } kind_type;

   // Pin register updates that go with a result beat.
   typedef enum logic [2:0] {
      PIN_HOLD,
      PIN_OE_OFF,
      PIN_OE_BLANK,
      PIN_LATCH_ON,
      PIN_LATCH_OFF,
      PIN_OE_LIT
   } pin_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STREAM,
      ST_LATCH_ON,
      ST_LATCH_OFF,
      ST_LIGHT
   } state_type;

   // Configuration register indexes.
   localparam logic CSR_OE_ACTIVE_HIGH   = 1'b0;
   localparam logic CSR_LATCH_PULSE_HIGH = 1'b1;

   localparam logic [7:0] BYTE_ONES  = 8'hFF;
   localparam logic [7:0] BYTE_ZEROS = 8'h00;

   typedef struct packed {
      logic       emit;
      kind_type   kind;
      logic       last;
      logic       acc_write;
      logic       mem_write;
      logic       mem_read;
      logic       clr_step;
      logic       idx_clear;
      logic       idx_step;
      logic       scan_set;
      logic       scan_clr;
      logic       row_adv;
      pin_op_type pin_op;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic idx_last;
      logic scan_en;
   } status_type;

endpackage

// ----- rtl/core/led_panel_row_scan_sequencer.sv -----
// ----------------------------------------------------------------------------
// led_panel_row_scan_sequencer
// Row scan sequencer for a multiplexed LED panel: scan buffer, row counter
// and row address, latch and output enable pin sequencing.
// ----------------------------------------------------------------------------
// After reset the block sweeps the scan buffer to its blank fill, one byte
// per cycle, and holds busy high until all ROWS*ROW_BYTES (512 by default)
// bytes are written; configuration writes are taken during that sweep. An item
// is taken when start is high and busy is low. Writes, scan on, scan off and
// a tick while stopped give one result beat in the cycle after the item and
// leave busy low. A tick while scanning gives ROW_BYTES+4 beats, one per
// cycle, starting the cycle after the item, and keeps busy high until its
// last beat is shown; the scan buffer's single read port sends one byte per
// cycle. Each beat is shown on the rsp_ ports for exactly one cycle, marked
// by rsp_valid; the receiver cannot stall it and must take every beat as it
// comes.
// ----------------------------------------------------------------------------
module led_panel_row_scan_sequencer
   import lprs_pkg::*;
#(
   parameter int ROWS        = 16,
   parameter int ROW_BYTES   = 32,
   parameter int BLANK_LEVEL = 0
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_op,
   input  logic [3:0] req_row_sel,
   input  logic [7:0] req_column,
   input  logic [7:0] req_data_in,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic       csr_wdata,
   output logic       rsp_valid,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_out,
   output logic [3:0] rsp_row_pins,
   output logic       rsp_latch_pin,
   output logic       rsp_oe_pin,
   output logic       rsp_accepted,
   output logic       rsp_last
);

   cmd_type    cmd;
   status_type status;

   lprs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   lprs_datapath #(
      .ROWS        (ROWS),
      .ROW_BYTES   (ROW_BYTES),
      .BLANK_LEVEL (BLANK_LEVEL)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_row_sel   (req_row_sel),
      .req_column    (req_column),
      .req_data_in   (req_data_in),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_data_out  (rsp_data_out),
      .rsp_row_pins  (rsp_row_pins),
      .rsp_latch_pin (rsp_latch_pin),
      .rsp_oe_pin    (rsp_oe_pin),
      .rsp_accepted  (rsp_accepted),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- rtl/core/lprs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lprs_ctrl
// Sequencer state machine. It runs the clearing pass after reset, takes
// items while idle and steps a row tick through blanking, byte streaming,
// latch pulse and relighting.
// ----------------------------------------------------------------------------
module lprs_ctrl
   import lprs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_op,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   op_type    op;

   assign op   = op_type'(req_op);
   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.kind   = KIND_ACK;
      cmd.pin_op = PIN_HOLD;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               unique case (op)
                  OP_WRITE: begin
                     cmd.mem_write = 1'b1;
                     cmd.acc_write = 1'b1;
                  end
                  OP_SCAN_ON: begin
                     cmd.scan_set = 1'b1;
                  end
                  OP_SCAN_OFF: begin
                     cmd.scan_clr = 1'b1;
                     cmd.kind     = KIND_PIN;
                     cmd.pin_op   = PIN_OE_OFF;
                  end
                  OP_TICK: begin
                     // A tick while stopped is only acknowledged.
                     if (status.scan_en) begin
                        cmd.last      = 1'b0;
                        cmd.kind      = KIND_PIN;
                        cmd.pin_op    = PIN_OE_BLANK;
                        cmd.mem_read  = 1'b1;
                        cmd.idx_clear = 1'b1;
                        state_in      = ST_STREAM;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_STREAM: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_DATA;
            if (status.idx_last) begin
               state_in = ST_LATCH_ON;
            end else begin
               cmd.mem_read = 1'b1;
               cmd.idx_step = 1'b1;
            end
         end
         ST_LATCH_ON: begin
            cmd.emit    = 1'b1;
            cmd.kind    = KIND_PIN;
            cmd.pin_op  = PIN_LATCH_ON;
            cmd.row_adv = 1'b1;
            state_in    = ST_LATCH_OFF;
         end
         ST_LATCH_OFF: begin
            cmd.emit   = 1'b1;
            cmd.kind   = KIND_PIN;
            cmd.pin_op = PIN_LATCH_OFF;
            state_in   = ST_LIGHT;
         end
         ST_LIGHT: begin
            cmd.emit   = 1'b1;
            cmd.kind   = KIND_PIN;
            cmd.pin_op = PIN_OE_LIT;
            cmd.last   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/lprs_datapath.sv -----
// ----------------------------------------------------------------------------
// lprs_datapath
// Scan buffer memory, scan row and byte counters, pin registers,
// configuration registers and the registered result beat.
// ----------------------------------------------------------------------------
module lprs_datapath
   import lprs_pkg::*;
#(
   parameter int ROWS        = 16,
   parameter int ROW_BYTES   = 32,
   parameter int BLANK_LEVEL = 0
)(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic [3:0] req_row_sel,
   input  logic [7:0] req_column,
   input  logic [7:0] req_data_in,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic       csr_wdata,
   output logic       rsp_valid,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_out,
   output logic [3:0] rsp_row_pins,
   output logic       rsp_latch_pin,
   output logic       rsp_oe_pin,
   output logic       rsp_accepted,
   output logic       rsp_last
);

   localparam int DEPTH = ROWS * ROW_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(ROW_BYTES);
   localparam logic [7:0] FILL_BYTE = (BLANK_LEVEL != 0) ? BYTE_ZEROS : BYTE_ONES;

   logic [7:0]    scan_mem_ff [DEPTH];
   logic [7:0]    mem_q_ff;

   logic [AW-1:0] clr_idx_ff, clr_idx_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [RW-1:0] scan_row_ff, scan_row_in;
   logic          scan_en_ff, scan_en_in;
   logic [3:0]    row_pin_ff, row_pin_in;
   logic          latch_ff, latch_in;
   logic          oe_ff, oe_in;
   logic          oe_hi_ff, latch_hi_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_kind_ff;
   logic [7:0]    rsp_data_ff;
   logic          rsp_acc_ff;
   logic          rsp_last_ff;

   logic          in_range;
   logic          mem_we;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] rd_col;
   logic [7:0]    wr_data;

   assign in_range = ({1'b0, req_row_sel} < 5'(ROWS)) && (req_column < 8'(ROW_BYTES));
   assign mem_we   = cmd.clr_step || (cmd.mem_write && in_range);
   assign wr_data  = cmd.clr_step ? FILL_BYTE : req_data_in;
   assign wr_addr  = cmd.clr_step ? clr_idx_ff
                   : AW'(AW'(req_row_sel[RW-1:0]) * AW'(ROW_BYTES) + AW'(req_column[CW-1:0]));

   // The first byte of a tick is fetched in the accept cycle; afterwards
   // the fetch runs one byte ahead of the byte being sent.
   assign rd_col  = cmd.idx_clear ? '0 : CW'(idx_ff + 1'b1);
   assign rd_addr = AW'(AW'(scan_row_ff) * AW'(ROW_BYTES) + AW'(rd_col));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         scan_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.mem_read) begin
         mem_q_ff <= scan_mem_ff[rd_addr];
      end
   end

   assign status.clr_done = (clr_idx_ff == AW'(DEPTH - 1));
   assign status.idx_last = (idx_ff == CW'(ROW_BYTES - 1));
   assign status.scan_en  = scan_en_ff;

   always_comb begin
      clr_idx_in  = cmd.clr_step ? AW'(clr_idx_ff + 1'b1) : clr_idx_ff;
      idx_in      = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = CW'(idx_ff + 1'b1);
      end
      scan_row_in = scan_row_ff;
      if (cmd.row_adv) begin
         scan_row_in = (scan_row_ff == RW'(ROWS - 1)) ? '0 : RW'(scan_row_ff + 1'b1);
      end
      scan_en_in = scan_en_ff;
      if (cmd.scan_set) begin
         scan_en_in = 1'b1;
      end else if (cmd.scan_clr) begin
         scan_en_in = 1'b0;
      end
      row_pin_in = row_pin_ff;
      latch_in   = latch_ff;
      oe_in      = oe_ff;
      case (cmd.pin_op)
         PIN_OE_OFF:    oe_in = 1'b1;
         PIN_OE_BLANK:  oe_in = ~oe_hi_ff;
         PIN_LATCH_ON: begin
            row_pin_in = 4'(scan_row_ff);
            latch_in   = latch_hi_ff;
         end
         PIN_LATCH_OFF: latch_in = ~latch_hi_ff;
         PIN_OE_LIT:    oe_in = oe_hi_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff   <= '0;
         idx_ff       <= '0;
         scan_row_ff  <= '0;
         scan_en_ff   <= 1'b0;
         row_pin_ff   <= '0;
         latch_ff     <= 1'b1;
         oe_ff        <= 1'b1;
         oe_hi_ff     <= 1'b0;
         latch_hi_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_idx_ff   <= clr_idx_in;
         idx_ff       <= idx_in;
         scan_row_ff  <= scan_row_in;
         scan_en_ff   <= scan_en_in;
         row_pin_ff   <= row_pin_in;
         latch_ff     <= latch_in;
         oe_ff        <= oe_in;
         rsp_valid_ff <= cmd.emit;
         if (csr_we) begin
            unique case (csr_index)
               CSR_OE_ACTIVE_HIGH:   oe_hi_ff    <= csr_wdata;
               CSR_LATCH_PULSE_HIGH: latch_hi_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Result payload; the pin levels come straight from the pin registers,
   // which only change together with a result beat.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff <= cmd.kind;
         rsp_data_ff <= (cmd.kind == KIND_DATA) ? mem_q_ff : BYTE_ZEROS;
         rsp_acc_ff  <= cmd.acc_write && in_range;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_row_pins  = row_pin_ff;
   assign rsp_latch_pin = latch_ff;
   assign rsp_oe_pin    = oe_ff;
   assign rsp_accepted  = rsp_acc_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
